// File: rtl/sds_pkg.sv
`timescale 1ns / 1ps
package sds_pkg;
  localparam int MAX_PARTICLES_DEF = 2048;
  localparam int COORD_BITS_DEF = 16;
  localparam int RADIUS_W = 15;
  localparam int SCALE_W = 16;
  localparam int COUNT_W = 12;
  localparam int DENSITY_W = 24;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // per-particle term handed from the distance pipe to the accumulator
  typedef struct packed {
    logic        valid;
    logic [31:0] term;
  } term_t;
endpackage

// File: rtl/sds_sqrt_pipe.sv
`timescale 1ns / 1ps
// Pipelined floor(sqrt) of a 32-bit value, one result bit per stage.
module sds_sqrt_pipe (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] radicand,
  input  logic [15:0] tag_h,
  output logic        out_valid,
  output logic [15:0] root,
  output logic [15:0] out_h
);
  localparam int STAGES = 16;

  logic                  vld [STAGES+1];
  logic [31:0]           rem [STAGES+1];
  logic [31:0]           val [STAGES+1];
  logic [15:0]           rt  [STAGES+1];
  logic [15:0]           hh  [STAGES+1];

  assign vld[0] = in_valid;
  assign val[0] = radicand;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign hh[0]  = tag_h;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [33:0] trial;
    logic [33:0] cur;
    always_comb begin
      cur   = {rem[s], val[s][31:30]};
      trial = {16'd0, rt[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      val[s+1] <= {val[s][29:0], 2'b00};
      hh[s+1]  <= hh[s];
      if (cur >= trial) begin
        rem[s+1] <= 32'(cur - trial);
        rt[s+1]  <= {rt[s][14:0], 1'b1};
      end else begin
        rem[s+1] <= 32'(cur);
        rt[s+1]  <= {rt[s][14:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign root      = rt[STAGES];
  assign out_h     = hh[STAGES];
endmodule

// File: rtl/sph_density_sum_top.sv
`timescale 1ns / 1ps
// Channel     | Signals                                | Transaction when
// ------------+----------------------------------------+--------------------
// command     | start, func, slot, point_x, point_y    | start && !busy
// result      | done, density_value                    | done (one cycle)
// config      | cfg_we, cfg_index, cfg_data            | cfg_we
// A load writes at the accepting edge and never raises busy. A query reads one
// table entry per cycle over n = min(particle_count, MAX_PARTICLES) entries;
// done rises once the terms have passed read, distance, 16-stage square root,
// multiply, accumulate and drain. busy drops at the edge that raises done.
// Synchronous reset clears control; the particle tables are not cleared.
// Results cannot stall.
module sph_density_sum_top #(
  parameter int MAX_PARTICLES = sds_pkg::MAX_PARTICLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic [10:0]                    slot,
  input  logic signed [15:0]             point_x,
  input  logic signed [15:0]             point_y,
  output logic                           done,
  output logic [sds_pkg::DENSITY_W-1:0]  density_value,
  input  logic                           cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sds_pkg::CFG_W-1:0]      cfg_data
);
  import sds_pkg::*;

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = AW + 1;
  localparam int DRAIN = 24;

  logic [RADIUS_W-1:0] kernel_radius;
  logic [SCALE_W-1:0]  kernel_scale;
  logic [COUNT_W-1:0]  particle_count;

  logic [15:0] x_mem [MAX_PARTICLES];
  logic [15:0] y_mem [MAX_PARTICLES];
  logic [15:0] rd_x, rd_y;

  state_t state, state_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] n_lim;
  logic [4:0]    drain_cnt;
  logic signed [15:0] qx, qy;
  logic [63:0]   acc;
  logic          accept;

  function automatic logic [16:0] ax_n(input logic signed [16:0] v);
    ax_n = v[16] ? 17'(-v) : 17'(v);
  endfunction

  always_comb begin
    if (32'(particle_count) > MAX_PARTICLES) n_lim = CW'(MAX_PARTICLES);
    else n_lim = CW'(particle_count);
  end

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_radius    <= RADIUS_W'(1229);
      kernel_scale     <= SCALE_W'(6036);
      particle_count   <= COUNT_W'(2048);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS: kernel_radius    <= cfg_data[RADIUS_W-1:0];
        CFG_SCALE:  kernel_scale     <= cfg_data;
        CFG_COUNT:  particle_count   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // table memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_LOAD && 32'(slot) < MAX_PARTICLES) begin
      x_mem[AW'(slot)] <= point_x;
      y_mem[AW'(slot)] <= point_y;
    end
    rd_x <= x_mem[idx[AW-1:0]];
    rd_y <= y_mem[idx[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && func == FUNC_QUERY) begin
        state_next = (n_lim == '0) ? ST_DRAIN : ST_SCAN;
      end
      ST_SCAN:  if (idx == n_lim - 1'b1) state_next = ST_DRAIN;
      ST_DRAIN: if (drain_cnt == 5'(DRAIN)) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      drain_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) idx <= '0;
      else if (state == ST_SCAN) idx <= idx + 1'b1;
      if (state == ST_DRAIN) drain_cnt <= drain_cnt + 1'b1;
      else drain_cnt <= '0;
    end
    if (accept) begin
      qx <= point_x;
      qy <= point_y;
    end
  end

  // stage 1: memory read valid; stage 2: differences
  logic        s1_v, s2_v, s3_v;
  logic [16:0] ax, ay;
  logic [33:0] d2;
  logic [31:0] d2_lim;
  logic        s2_in, s3_in;
  logic [29:0] h2;

  always_comb begin
    h2 = 30'(kernel_radius) * 30'(kernel_radius);
  end

  logic signed [16:0] dxs, dys;
  always_comb begin
    dxs = 17'(signed'(rd_x)) - 17'(qx);
    dys = 17'(signed'(rd_y)) - 17'(qy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= (state == ST_SCAN);
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
    ax <= dxs[16] ? 17'(-dxs) : 17'(dxs);
    ay <= dys[16] ? 17'(-dys) : 17'(dys);
    s2_in <= (ax_n(dxs) < 17'(kernel_radius)) && (ax_n(dys) < 17'(kernel_radius));
    d2 <= 34'(ax) * 34'(ax) + 34'(ay) * 34'(ay);
    s3_in <= s2_in;
  end

  logic in_rad;
  assign in_rad = s3_in && (d2 < 34'(h2));
  assign d2_lim = d2[31:0];

  logic        sq_v;
  logic [15:0] root, sq_h;
  sds_sqrt_pipe u_sqrt (
    .clk(clk), .rst(rst),
    .in_valid(s3_v && in_rad),
    .radicand(d2_lim),
    .tag_h(16'(kernel_radius)),
    .out_valid(sq_v), .root(root), .out_h(sq_h)
  );

  term_t g2, term;
  logic [15:0] g;
  assign g = sq_h - root;
  always_ff @(posedge clk) begin
    if (rst) begin
      g2.valid   <= 1'b0;
      term.valid <= 1'b0;
    end else begin
      g2.valid   <= sq_v;
      term.valid <= g2.valid;
    end
    g2.term   <= 32'(g) * 32'(g);
    term.term <= g2.term;
  end

  logic [47:0] prod;
  logic        prod_v;
  always_ff @(posedge clk) begin
    if (rst) prod_v <= 1'b0;
    else prod_v <= term.valid;
    prod <= 48'(term.term) * 48'(kernel_scale);
    if (accept) acc <= '0;
    else if (prod_v) acc <= acc + 64'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (state == ST_DONE);
    density_value <= (acc[63:24] > 40'hFFFFFF) ? 24'hFFFFFF : acc[47:24];
  end

  a_done_after_done_state: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_DONE) else $error("done without done state");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> idx < n_lim) else $error("scan index beyond count");
  a_no_work_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !prod_v) else $error("accumulate while idle");
endmodule

// File: tb/sph_density_sum_top_test.sv
`timescale 1ns / 1ps
module sph_density_sum_top_test;
  import sds_pkg::*;

  typedef enum {OP_CMD, OP_CFG, OP_SYNC} op_kind_t;

  typedef struct {
    op_kind_t              kind;
    logic                  func;
    logic [10:0]           slot;
    logic signed [15:0]    px;
    logic signed [15:0]    py;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
    int                    gap;
  } op_t;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  start = 0;
  logic                  busy;
  logic                  func = FUNC_LOAD;
  logic [10:0]           slot = '0;
  logic signed [15:0]    point_x = '0;
  logic signed [15:0]    point_y = '0;
  logic                  done;
  logic [DENSITY_W-1:0]  density_value;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RADIUS;
  logic [CFG_W-1:0]      cfg_data = '0;

  sph_density_sum_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .slot(slot),
    .point_x(point_x), .point_y(point_y), .done(done),
    .density_value(density_value), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [15:0]     pos_x [MAX_PARTICLES_DEF];
  logic signed [15:0]     pos_y [MAX_PARTICLES_DEF];
  logic [RADIUS_W-1:0]    radius_q = 15'd1229;
  logic [SCALE_W-1:0]     scale_q = 16'd6036;
  logic [COUNT_W-1:0]     count_q = 12'd2048;

  op_t                    pending_ops [$];
  logic [DENSITY_W-1:0]   expected_density [$];
  int                     errors = 0;
  bit                     taken = 0;

  // generator bookkeeping
  int                     loaded_n = 0;
  int                     gen_radius = 1229;
  bit                     no_gaps = 0;

  function automatic longint floor_sqrt(longint v);
    longint root;
    longint b;
    root = 0;
    b = longint'(1) << 30;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic logic [DENSITY_W-1:0] density_at(logic signed [15:0] qx,
                                                      logic signed [15:0] qy);
    longint h, n, ax, ay, d2, g;
    longint unsigned acc;
    h = radius_q;
    n = count_q;
    acc = 0;
    if (n > MAX_PARTICLES_DEF) n = MAX_PARTICLES_DEF;
    for (int i = 0; i < n; i++) begin
      ax = longint'(pos_x[i]) - longint'(qx);
      ay = longint'(pos_y[i]) - longint'(qy);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      if (ax >= h || ay >= h) continue;
      d2 = ax * ax + ay * ay;
      if (d2 >= h * h) continue;
      g = h - floor_sqrt(d2);
      acc += longint'(g * g) * longint'(scale_q);
    end
    acc >>= 24;
    if (acc > 64'hFFFFFF) acc = 64'hFFFFFF;
    return acc[DENSITY_W-1:0];
  endfunction

  // monitor: transactions, config writes and results at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      taken <= 0;
    end else begin
      if (done) begin
        if (expected_density.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time,
                   density_value);
          errors++;
        end else begin
          logic [DENSITY_W-1:0] e;
          e = expected_density.pop_front();
          if (density_value !== e) begin
            $display("%0t: density_value mismatch, expected %0d, actual %0d",
                     $time, e, density_value);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (func == FUNC_QUERY) begin
          expected_density.push_back(density_at(point_x, point_y));
        end else begin
          pos_x[slot] = point_x;
          pos_y[slot] = point_y;
        end
      end
      taken <= start && !busy;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RADIUS: radius_q = cfg_data[RADIUS_W-1:0];
          CFG_SCALE:  scale_q = cfg_data[SCALE_W-1:0];
          CFG_COUNT:  count_q = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // driver: one item at a time, inputs change on the falling edge
  int gap_left = 0;
  int idle_left = 0;

  always @(negedge clk) begin
    logic nstart;
    logic nwe;
    op_t  op;
    nstart = start;
    nwe = 0;
    if (!rst) begin
      if (start && taken) nstart = 0;
      if (!nstart) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (idle_left > 0) begin
          if (expected_density.size() == 0 && !busy) idle_left--;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops.pop_front();
          case (op.kind)
            OP_CMD: begin
              nstart = 1;
              func <= op.func;
              slot <= op.slot;
              point_x <= op.px;
              point_y <= op.py;
              gap_left = op.gap;
            end
            OP_CFG: begin
              nwe = 1;
              cfg_index <= op.idx;
              cfg_data <= op.data;
            end
            default: idle_left = op.gap;
          endcase
        end
      end
    end
    start <= nstart;
    cfg_we <= nwe;
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic void add_cmd(logic f, logic [10:0] s, logic [15:0] x, logic [15:0] y);
    op_t op;
    op.kind = OP_CMD;
    op.func = f;
    op.slot = s;
    op.px = x;
    op.py = y;
    op.gap = draw_gap();
    pending_ops.push_back(op);
  endfunction

  function automatic void add_load(int s, logic [15:0] x, logic [15:0] y);
    add_cmd(FUNC_LOAD, s[10:0], x, y);
    if (s == loaded_n) loaded_n++;
  endfunction

  function automatic void add_query(logic [15:0] x, logic [15:0] y);
    add_cmd(FUNC_QUERY, 11'd0, x, y);
  endfunction

  // wait until idle, then a settle window before the next writes
  function automatic void add_sync();
    op_t op;
    op.kind = OP_SYNC;
    op.gap = 40;
    pending_ops.push_back(op);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] i, int v);
    op_t op;
    op.kind = OP_CFG;
    op.idx = i;
    op.data = v[CFG_W-1:0];
    op.gap = 0;
    pending_ops.push_back(op);
    if (i == CFG_RADIUS) gen_radius = v & 16'h7FFF;
  endfunction

  function automatic logic [15:0] near(int c);
    int r;
    r = gen_radius * 2;
    if (r > 32767) r = 32767;
    if (r < 2) r = 2;
    return 16'(c + $urandom_range(0, 2 * r) - r);
  endfunction

  initial begin
    int centre_x, centre_y, cnt, pick;
    // directed: field extremes, saturation, zero radius, zero count
    add_sync();
    add_cfg(CFG_COUNT, 8);
    add_load(0, 16'h0000, 16'h0000);
    add_load(1, 16'h7FFF, 16'h7FFF);
    add_load(2, 16'h8000, 16'h8000);
    add_load(3, 16'h0064, 16'hFFCE);
    for (int i = 4; i < 8; i++) add_load(i, 16'h0010 * i, 16'hFFF0);
    add_query(16'h0000, 16'h0000);
    add_query(16'h7FFF, 16'h7FFF);
    add_query(16'h8000, 16'h8000);
    add_query(16'h7FFF, 16'h8000);
    add_query(16'h0050, 16'hFFF0);
    add_sync();
    add_cfg(CFG_RADIUS, 32767);
    add_cfg(CFG_SCALE, 65535);
    add_query(16'h0000, 16'h0000);  // saturates
    add_query(16'h8000, 16'h7FFF);
    add_sync();
    add_cfg(CFG_RADIUS, 0);
    add_query(16'h0000, 16'h0000);
    add_sync();
    add_cfg(CFG_RADIUS, 1);
    add_cfg(CFG_COUNT, 0);
    add_query(16'h0000, 16'h0000);
    add_sync();
    add_cfg(CFG_COUNT, 8);
    add_query(16'h0000, 16'h0000);

    // random phases over clustered particles
    for (int p = 0; p < 9; p++) begin
      add_sync();
      pick = $urandom_range(0, 5);
      case (pick)
        0: add_cfg(CFG_RADIUS, 1);
        1: add_cfg(CFG_RADIUS, 32767);
        2: add_cfg(CFG_RADIUS, 1229);
        3: add_cfg(CFG_RADIUS, 4096);
        default: add_cfg(CFG_RADIUS, $urandom_range(1, 8000));
      endcase
      pick = $urandom_range(0, 3);
      add_cfg(CFG_SCALE, pick == 0 ? 0 : pick == 1 ? 65535 : $urandom_range(0, 65535));
      cnt = (p % 4 == 3) ? 0 : $urandom_range(1, loaded_n < 40 ? loaded_n : 40);
      add_cfg(CFG_COUNT, cnt);
      no_gaps = (p % 3 == 1);
      centre_x = $urandom_range(0, 65535) - 32768;
      centre_y = $urandom_range(0, 65535) - 32768;
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(0, 9) < 4) begin
          int s;
          s = $urandom_range(0, loaded_n < 2047 ? loaded_n : 2047);
          if ($urandom_range(0, 7) == 0)
            add_load(s, 16'($urandom), 16'($urandom));
          else
            add_load(s, near(centre_x), near(centre_y));
        end else if ($urandom_range(0, 5) == 0) begin
          add_query(16'($urandom), 16'($urandom));
        end else begin
          add_query(near(centre_x), near(centre_y));
        end
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 0;
    do @(posedge clk);
    while (pending_ops.size() > 0 || start || gap_left > 0 || idle_left > 0 ||
           expected_density.size() > 0 || busy);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_density.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end
endmodule
